// ===== src/sle_pkg.sv =====
`timescale 1ns / 1ps
// sle_pkg: shared constants, command/status codes and cell control types
// for the sequential list engine. No dependencies.
package sle_pkg;

   // default store depth and compare width (covers depths up to 4096 plus margin)
   localparam int CAPACITY_DEF = 256;
   localparam int CMP_W        = 14;
   localparam int POS_W        = 9;
   localparam int VAL_W        = 8;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_GET    = 3'd2,
      CMD_LOCATE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_INSERT    = 3'd1,
      CELL_DELETE    = 3'd2,
      CELL_PROBE_POS = 3'd3,
      CELL_PROBE_VAL = 3'd4,
      CELL_SHIFT     = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [CMP_W-1:0]  pos0;    // 0-based target position
      logic [CMP_W-1:0]  count;   // current element count
      logic [VAL_W-1:0]  value;   // byte to insert or match
   } cell_ctrl_type;

endpackage

// ===== src/sle_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces for the sequential list engine.
// Depends on nothing; widths match sle_pkg field widths.
interface sle_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [8:0] position;
   logic [7:0] value_in;

   modport source (output valid, output cmd, output position, output value_in,
                   input ready);
   modport sink   (input valid, input cmd, input position, input value_in,
                   output ready);
endinterface

interface sle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] value_out;
   logic [8:0] found_position;
   logic [8:0] list_length;
   logic       is_empty;

   modport source (output valid, output status, output value_out,
                   output found_position, output list_length, output is_empty,
                   input ready);
   modport sink   (input valid, input status, input value_out,
                   input found_position, input list_length, input is_empty,
                   output ready);
endinterface

// ===== src/sequential_list_engine_unit.sv =====
`timescale 1ns / 1ps
// sequential_list_engine_unit: ordered byte list held in a chain of cells.
// Depends on sle_pkg, sle_if (sle_req_if, sle_rsp_if) and sle_cell.
//
// Usage:
//  - req_ch carries one command per transaction (cmd, position, value_in);
//    rsp_ch returns exactly one result per command (status, value_out,
//    found_position, list_length, is_empty), in order.
//  - Insert, clear, unused codes and out-of-range commands: the result is
//    registered in the cycle after the request transaction. Insert shifts all
//    later cells up at the edge that registers the result.
//  - Get and delete: the cells snapshot a hit mark into their probe stages,
//    which then shift one cell per cycle toward the head; the result is
//    registered when the hit reaches the head. Delete shifts the later cells
//    down on the cycle the hit reaches the head.
//  - Locate: same probe shift with value matches; the result is registered when
//    the first match reaches the head, or as not-found after the last element.
//    Locate on an empty list answers not-found in the cycle after the request.
//  - One command is in flight at a time: req_ch.ready is high only when no
//    scan runs and the output register is empty or being drained.
//  - A stalled rsp_ch holds its result; req_ch stays blocked meanwhile.
//  - Synchronous reset empties the list (length 0) and drops any pending
//    result. Store contents are not cleared; only entries below the length
//    are ever read.
module sequential_list_engine_unit #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sle_req_if.sink       req_ch,
   sle_rsp_if.source     rsp_ch
);
   localparam int CW    = sle_pkg::CMP_W;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VW    = sle_pkg::VAL_W;
   localparam int PW    = sle_pkg::POS_W;

   // one-hot controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        step_ff, step_in;      // probe shifts done so far
   logic                    del_ff, del_in;        // scan belongs to a delete
   logic [CW-1:0]           pos0_ff, pos0_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic [VW-1:0]           value_out_ff, value_out_in;
   logic [PW-1:0]           found_ff, found_in;
   logic [PW-1:0]           length_ff, length_in;
   logic                    empty_ff, empty_in;

   sle_pkg::cell_ctrl_type  ctrl;

   logic [VW-1:0] elem_w [CAPACITY];
   logic          hit_w  [CAPACITY];
   logic [VW-1:0] val_w  [CAPACITY];

   logic          req_fire;
   logic [CW-1:0] req_pos;
   logic [CW-1:0] cnt_ext;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_pos      = CW'(req_ch.position);
   assign cnt_ext      = CW'(count_ff);

   // ---------------------------------------------------------------- chain
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VW-1:0] left_e, right_e, right_v;
         logic          right_h;
         if (gi == 0) begin : g_head
            assign left_e = '0;
         end else begin : g_mid
            assign left_e = elem_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_e = '0;
            assign right_h = 1'b0;
            assign right_v = '0;
         end else begin : g_body
            assign right_e = elem_w[gi+1];
            assign right_h = hit_w[gi+1];
            assign right_v = val_w[gi+1];
         end
         sle_cell #(.INDEX(gi)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .left_elem  (left_e),
            .right_elem (right_e),
            .right_hit  (right_h),
            .right_val  (right_v),
            .elem       (elem_w[gi]),
            .hit        (hit_w[gi]),
            .val        (val_w[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      del_in       = del_ff;
      pos0_in      = pos0_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      value_out_in = value_out_ff;
      found_in     = found_ff;
      length_in    = length_ff;
      empty_in     = empty_ff;

      ctrl.op    = sle_pkg::CELL_HOLD;
      ctrl.pos0  = req_pos - CW'(1);
      ctrl.count = cnt_ext;
      ctrl.value = req_ch.value_in;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               status_in    = sle_pkg::ST_OK;
               value_out_in = '0;
               found_in     = '0;
               pos0_in      = req_pos - CW'(1);
               case (req_ch.cmd)
                  sle_pkg::CMD_INSERT: begin
                     if (req_pos < CW'(1) || req_pos > cnt_ext + CW'(1)) begin
                        status_in = sle_pkg::ST_RANGE;
                     end else if (cnt_ext >= CW'(CAPACITY)) begin
                        status_in = sle_pkg::ST_FULL;
                     end else begin
                        ctrl.op  = sle_pkg::CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  sle_pkg::CMD_DELETE,
                  sle_pkg::CMD_GET: begin
                     if (req_pos < CW'(1) || req_pos > cnt_ext) begin
                        status_in = sle_pkg::ST_RANGE;
                     end else begin
                        ctrl.op      = sle_pkg::CELL_PROBE_POS;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        step_in      = '0;
                        del_in       = (req_ch.cmd == sle_pkg::CMD_DELETE);
                     end
                  end
                  sle_pkg::CMD_LOCATE: begin
                     if (count_ff == '0) begin
                        status_in = sle_pkg::ST_NOTFOUND;
                     end else begin
                        ctrl.op      = sle_pkg::CELL_PROBE_VAL;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        step_in      = '0;
                        del_in       = 1'b0;
                     end
                  end
                  sle_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // probe head sits in cell 0; step_ff is its 0-based position
            ctrl.pos0 = pos0_ff;
            if (hit_w[0]) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               status_in    = sle_pkg::ST_OK;
               value_out_in = del_ff ? val_w[0] : (pos0_ff == CW'(step_ff) ? val_w[0] : '0);
               found_in     = (del_ff || pos0_ff == CW'(step_ff)) ? '0 :
                              PW'(CW'(step_ff) + CW'(1));
               if (del_ff) begin
                  ctrl.op  = sle_pkg::CELL_DELETE;
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (step_ff == count_ff - CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               status_in    = sle_pkg::ST_NOTFOUND;
               value_out_in = '0;
               found_in     = '0;
            end else begin
               ctrl.op = sle_pkg::CELL_SHIFT;
               step_in = step_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      length_in = PW'(count_in);
      empty_in  = (count_in == '0);
   end

   // Result kind is tracked so get and locate can share the scan: a get
   // scan targets pos0, a locate scan is started with pos0 past the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      del_ff       <= del_in;
      pos0_ff      <= (req_fire && req_ch.cmd == sle_pkg::CMD_LOCATE) ? {CW{1'b1}} : pos0_in;
      status_ff    <= status_in;
      value_out_ff <= value_out_in;
      found_ff     <= found_in;
      length_ff    <= length_in;
      empty_ff     <= empty_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.value_out      = value_out_ff;
   assign rsp_ch.found_position = found_ff;
   assign rsp_ch.list_length    = length_ff;
   assign rsp_ch.is_empty       = empty_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(count_ff) <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !rsp_valid_ff)
      else $error("result pending while a scan runs");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.cmd == sle_pkg::CMD_CLEAR) |=> (count_ff == '0) && empty_ff)
      else $error("clear did not empty the list");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (step_ff < count_ff))
      else $error("probe scan ran past the list");
endmodule

// ===== src/sle_cell.sv =====
`timescale 1ns / 1ps
// sle_cell: one list slot plus a probe stage that shifts toward the head.
// Depends on sle_pkg.
module sle_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  sle_pkg::cell_ctrl_type        ctrl,
   input  logic [sle_pkg::VAL_W-1:0]     left_elem,
   input  logic [sle_pkg::VAL_W-1:0]     right_elem,
   input  logic                          right_hit,
   input  logic [sle_pkg::VAL_W-1:0]     right_val,
   output logic [sle_pkg::VAL_W-1:0]     elem,
   output logic                          hit,
   output logic [sle_pkg::VAL_W-1:0]     val
);
   localparam int CW = sle_pkg::CMP_W;
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [sle_pkg::VAL_W-1:0] elem_ff, elem_in;
   logic                      hit_ff, hit_in;
   logic [sle_pkg::VAL_W-1:0] val_ff, val_in;

   always_comb begin
      elem_in = elem_ff;
      hit_in  = hit_ff;
      val_in  = val_ff;
      case (ctrl.op)
         sle_pkg::CELL_INSERT: begin
            if (IDX > ctrl.pos0) begin
               elem_in = left_elem;
            end else if (IDX == ctrl.pos0) begin
               elem_in = ctrl.value;
            end
         end
         sle_pkg::CELL_DELETE: begin
            if (IDX >= ctrl.pos0) begin
               elem_in = right_elem;
            end
         end
         sle_pkg::CELL_PROBE_POS: begin
            hit_in = (IDX < ctrl.count) && (IDX == ctrl.pos0);
            val_in = elem_ff;
         end
         sle_pkg::CELL_PROBE_VAL: begin
            hit_in = (IDX < ctrl.count) && (elem_ff == ctrl.value);
            val_in = elem_ff;
         end
         sle_pkg::CELL_SHIFT: begin
            hit_in = right_hit;
            val_in = right_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      hit_ff  <= hit_in;
      val_ff  <= val_in;
   end

   assign elem = elem_ff;
   assign hit  = hit_ff;
   assign val  = val_ff;
endmodule
